[src/arpc_pkg.sv]
// arpc_pkg: shared types and constants for the arp cache responder
// no dependencies
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] OP_RX = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REG = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_OURS = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] ARP_REQ = 2'd1;
  localparam logic [1:0] ARP_REPLY = 2'd2;

  localparam logic CFG_OWN_IP = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_READMAC,
    S_OUT
  } state_t;

endpackage

[src/arp_cache_responder_core.sv]
// arp_cache_responder_core: arp cache with automatic request/reply generation
// depends on arpc_pkg and arpc_ram
//
// usage: one input beat in (valid/ready), one result beat out per input beat.
// opcode 0 takes a received arp payload, 1 looks up peer_ip, 2 registers
// peer_ip to peer_mac. own_ip and own_mac are written on the cfg port
// (cfg_index 0 and 1); the user must write them only while the block is
// idle; the block does not enforce it. entries fill from the lowest index
// and are never evicted, so the used entries are always indexes 0..count-1.
// the key search reads the ip memory one entry a cycle over the used entries
// only (count = used entries, at most TABLE_ENTRIES), through its single
// read port, and stops on a hit. a beat then goes to decide, reads the mac
// memory on a lookup hit of a resolved entry, and waits as a result beat.
// one beat is processed at a time: the next input beat can be taken in the
// cycle after the result beat is accepted.
// reset clears the fill count and resolved flags; no clearing pass.
// a stalled receiver holds the result, and no new input is taken until it
// is taken.
module arp_cache_responder_core
  import arpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] payload_bytes,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_addr_len,
  input  logic [7:0]  proto_addr_len,
  input  logic [15:0] arp_oper,
  input  logic [47:0] peer_mac,
  input  logic [31:0] peer_ip,
  input  logic [31:0] asked_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [47:0] result_mac,
  output logic        send_frame,
  output logic [1:0]  frame_oper,
  output logic [47:0] frame_dest_mac,
  output logic [47:0] frame_target_mac,
  output logic [31:0] frame_target_ip
);

  state_t state, state_next;
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [CNT_W-1:0] count;
  logic [TABLE_ENTRIES-1:0] resolved;

  logic [1:0]  op_q;
  logic        valid_q;
  logic        req_q;
  logic [47:0] mac_q;
  logic [31:0] ip_q;
  logic [CNT_W-1:0] scan;
  logic        rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic        found;
  logic [IDX_W-1:0] hit_idx;

  logic ip_we, mac_we;
  logic [IDX_W-1:0] ip_raddr, mac_raddr, wr_idx;
  logic [31:0] ip_rdata;
  logic [47:0] mac_rdata;

  logic full;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign full = (count == CNT_W'(TABLE_ENTRIES));
  assign ip_raddr = scan[IDX_W-1:0];
  assign mac_raddr = hit_idx;

  arpc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_ip_ram (
    .clk(clk), .we(ip_we), .waddr(wr_idx), .wdata(ip_q),
    .raddr(ip_raddr), .rdata(ip_rdata)
  );

  arpc_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
    .clk(clk), .we(mac_we), .waddr(wr_idx), .wdata(mac_q),
    .raddr(mac_raddr), .rdata(mac_rdata)
  );

  // learn or allocate decision
  logic do_learn, do_alloc;
  always_comb begin
    do_learn = (op_q == OP_RX && valid_q) || op_q == OP_REG;
    do_alloc = (op_q == OP_LOOKUP) && !found && !full;
    wr_idx = found ? hit_idx : count[IDX_W-1:0];
    ip_we = (state == S_DECIDE) && !found && !full && (do_learn || do_alloc);
    mac_we = (state == S_DECIDE) && do_learn && (found || !full);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SEARCH;
      S_SEARCH: if (found || (!rd_pend && scan >= count)) state_next = S_DECIDE;
      S_DECIDE: state_next = (op_q == OP_LOOKUP && found && resolved[hit_idx])
                             ? S_READMAC : S_OUT;
      S_READMAC: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      own_ip <= '0;
      own_mac <= '0;
      count <= '0;
      resolved <= '0;
      rd_pend <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_OWN_IP) own_ip <= cfg_data[31:0];
        else own_mac <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          found <= 1'b0;
          scan <= '0;
        end
        S_SEARCH: begin
          if (rd_pend && ip_rdata == ip_q) begin
            found <= 1'b1;
            hit_idx <= rd_idx;
            rd_pend <= 1'b0;
          end else if (!found) begin
            rd_pend <= (scan < count);
            rd_idx <= scan[IDX_W-1:0];
            if (scan < count) scan <= scan + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          if (ip_we) count <= count + CNT_W'(1);
          if (mac_we) resolved[wr_idx] <= 1'b1;
          else if (ip_we) resolved[wr_idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q <= opcode;
      valid_q <= payload_bytes >= 16'd28 && hw_type == 16'd1 &&
                 proto_type == 16'h0800 && hw_addr_len == 8'd6 &&
                 proto_addr_len == 8'd4;
      req_q <= arp_oper == 16'd1 && asked_ip == own_ip;
      mac_q <= peer_mac;
      ip_q <= peer_ip;
    end
    if (state == S_DECIDE) begin
      status <= ST_NOT_OURS;
      result_mac <= '0;
      send_frame <= 1'b0;
      frame_oper <= '0;
      frame_dest_mac <= '0;
      frame_target_mac <= '0;
      frame_target_ip <= '0;
      case (op_q)
        OP_RX: if (valid_q) begin
          if (!found && full) status <= ST_FULL;
          else begin
            status <= ST_OK;
            if (req_q) begin
              send_frame <= 1'b1;
              frame_oper <= ARP_REPLY;
              frame_dest_mac <= mac_q;
              frame_target_mac <= mac_q;
              frame_target_ip <= ip_q;
            end
          end
        end
        OP_LOOKUP: begin
          if (found) status <= resolved[hit_idx] ? ST_OK : ST_PENDING;
          else if (full) status <= ST_FULL;
          else begin
            status <= ST_PENDING;
            send_frame <= 1'b1;
            frame_oper <= ARP_REQ;
            frame_dest_mac <= '1;
            frame_target_ip <= ip_q;
          end
        end
        OP_REG: status <= (!found && full) ? ST_FULL : ST_OK;
        default: ;
      endcase
    end
    if (state == S_READMAC) result_mac <= mac_rdata;
  end

  // own_mac is sender of emitted frames, not an output field
  logic unused_own_mac;
  assign unused_own_mac = ^own_mac;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count overflow");
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result waits");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> $past(state) == S_DECIDE)
    else $error("count changed outside decide");
  a_frame_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_frame |-> status == ST_OK || status == ST_PENDING)
    else $error("frame with bad status");

endmodule

[src/arpc_ram.sv]
// arpc_ram: generic single write, single read ram with registered read
// no dependencies
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/tb_arp_cache_responder_core.sv]
// tb_arp_cache_responder_core: self-checking testbench for the arp cache responder
// depends on arpc_pkg and arp_cache_responder_core; keeps its own table model
`timescale 1ns / 1ps

module tb_arp_cache_responder_core
  import arpc_pkg::*;
();

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] nbytes;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] oper;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] tip;
  } arp_req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [47:0] rmac;
    logic        snd;
    logic [1:0]  foper;
    logic [47:0] fdst;
    logic [47:0] ftmac;
    logic [31:0] ftip;
  } arp_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [15:0] payload_bytes = '0;
  logic [15:0] hw_type = '0;
  logic [15:0] proto_type = '0;
  logic [7:0] hw_addr_len = '0;
  logic [7:0] proto_addr_len = '0;
  logic [15:0] arp_oper = '0;
  logic [47:0] peer_mac = '0;
  logic [31:0] peer_ip = '0;
  logic [31:0] asked_ip = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [47:0] result_mac;
  logic send_frame;
  logic [1:0] frame_oper;
  logic [47:0] frame_dest_mac;
  logic [47:0] frame_target_mac;
  logic [31:0] frame_target_ip;

  arp_cache_responder_core dut (.*);

  initial forever #4 clk = ~clk;

  logic        tbl_used [TABLE_ENTRIES];
  logic        tbl_res  [TABLE_ENTRIES];
  logic [31:0] tbl_ip   [TABLE_ENTRIES];
  logic [47:0] tbl_mac  [TABLE_ENTRIES];
  logic [31:0] my_ip = '0;
  logic [47:0] my_mac = '0;
  arp_resp_t expected_q[$];
  int errors = 0;
  int burst_left = 0;
  logic [31:0] ip_pool [8];

  function automatic int find_ip(logic [31:0] ip);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_used[i] && tbl_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int find_slot();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!tbl_used[i]) return i;
    return -1;
  endfunction

  function automatic logic learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int i;
    i = find_ip(ip);
    if (i < 0) begin
      i = find_slot();
      if (i < 0) return 1'b0;
      tbl_used[i] = 1'b1;
      tbl_ip[i] = ip;
    end
    tbl_mac[i] = mac;
    tbl_res[i] = 1'b1;
    return 1'b1;
  endfunction

  function automatic arp_resp_t predict_response(arp_req_t r);
    arp_resp_t e;
    int i;
    e = '0;
    e.st = ST_NOT_OURS;
    if (r.op == OP_RX) begin
      if (r.nbytes < 16'd28 || r.htype != 16'd1 || r.ptype != 16'h0800 ||
          r.hlen != 8'd6 || r.plen != 8'd4) return e;
      if (!learn_mapping(r.ip, r.mac)) begin
        e.st = ST_FULL;
        return e;
      end
      e.st = ST_OK;
      if (r.oper == 16'd1 && r.tip == my_ip) begin
        e.snd = 1'b1;
        e.foper = ARP_REPLY;
        e.fdst = r.mac;
        e.ftmac = r.mac;
        e.ftip = r.ip;
      end
    end else if (r.op == OP_LOOKUP) begin
      i = find_ip(r.ip);
      if (i >= 0) begin
        if (tbl_res[i]) begin
          e.st = ST_OK;
          e.rmac = tbl_mac[i];
        end else e.st = ST_PENDING;
        return e;
      end
      i = find_slot();
      if (i < 0) begin
        e.st = ST_FULL;
        return e;
      end
      tbl_used[i] = 1'b1;
      tbl_res[i] = 1'b0;
      tbl_ip[i] = r.ip;
      e.st = ST_PENDING;
      e.snd = 1'b1;
      e.foper = ARP_REQ;
      e.fdst = '1;
      e.ftip = r.ip;
    end else if (r.op == OP_REG) begin
      e.st = learn_mapping(r.ip, r.mac) ? ST_OK : ST_FULL;
    end
    return e;
  endfunction

  task automatic send_request(arp_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= r.op;
    payload_bytes <= r.nbytes;
    hw_type <= r.htype;
    proto_type <= r.ptype;
    hw_addr_len <= r.hlen;
    proto_addr_len <= r.plen;
    arp_oper <= r.oper;
    peer_mac <= r.mac;
    peer_ip <= r.ip;
    asked_ip <= r.tip;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_response(r));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_IP) my_ip = val[31:0];
    else my_mac = val;
    @(posedge clk);
  endtask

  function automatic arp_req_t good_rx(logic [15:0] oper, logic [47:0] mac,
                                       logic [31:0] ip, logic [31:0] tip);
    arp_req_t r;
    r = '{op: OP_RX, nbytes: 16'd28, htype: 16'd1, ptype: 16'h0800, hlen: 8'd6,
          plen: 8'd4, oper: oper, mac: mac, ip: ip, tip: tip};
    return r;
  endfunction

  function automatic arp_req_t rand_req();
    arp_req_t r;
    int k;
    logic [255:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = rbits[$bits(arp_req_t)-1:0];
    k = $urandom_range(0, 9);
    r.ip = (k < 8) ? ip_pool[$urandom_range(0, 7)] : $urandom;
    if ($urandom_range(0, 3) != 0) r.tip = ($urandom_range(0, 1) != 0) ? my_ip : r.ip;
    if ($urandom_range(0, 9) == 0) return r;
    r.op = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 7) != 0) begin
      r.nbytes = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(28, 200));
      r.htype = 16'd1;
      r.ptype = 16'h0800;
      r.hlen = 8'd6;
      r.plen = 8'd4;
      r.oper = 16'($urandom_range(0, 3));
    end else begin
      case ($urandom_range(0, 4))
        0: r.nbytes = 16'($urandom_range(0, 27));
        1: r.htype = 16'd1 ^ (16'd1 << $urandom_range(0, 15));
        2: r.ptype = 16'h0800 ^ (16'd1 << $urandom_range(0, 15));
        3: r.hlen = 8'd6 ^ (8'd1 << $urandom_range(0, 7));
        default: r.plen = 8'd4 ^ (8'd1 << $urandom_range(0, 7));
      endcase
    end
    return r;
  endfunction

  task automatic test_directed();
    arp_req_t r;
    write_reg(CFG_OWN_IP, 48'hffff_ffff);
    write_reg(CFG_OWN_MAC, '1);
    send_request(good_rx(16'd1, 48'h0000_0000_0001, 32'h0a00_0001, 32'hffff_ffff));
    send_request(good_rx(16'd2, '1, 32'hffff_ffff, 32'h0));
    send_request(good_rx(16'd1, 48'h1234, 32'h0, 32'h1));
    r = good_rx(16'd1, 48'h5, 32'h7, 32'hffff_ffff); r.nbytes = 16'd27;
    send_request(r);
    r = good_rx(16'd1, 48'h5, 32'h7, 32'hffff_ffff); r.htype = 16'd2;
    send_request(r);
    r = good_rx(16'd1, 48'h5, 32'h7, 32'hffff_ffff); r.ptype = 16'h86dd;
    send_request(r);
    r = good_rx(16'd1, 48'h5, 32'h7, 32'hffff_ffff); r.hlen = 8'hff;
    send_request(r);
    r = good_rx(16'd1, 48'h5, 32'h7, 32'hffff_ffff); r.plen = 8'h0;
    send_request(r);
    r = good_rx(16'hffff, 48'h5, 32'h7, 32'h0); r.op = 2'd3;
    send_request(r);
    r.op = OP_LOOKUP; r.ip = 32'h0a00_0001;
    send_request(r);
    r.ip = 32'hc0a8_0001;
    send_request(r);
    send_request(r);
    r.op = OP_REG; r.mac = 48'hfedc_ba98_7654;
    send_request(r);
    r.op = OP_LOOKUP;
    send_request(r);
    drain();
    write_reg(CFG_OWN_IP, 48'h0);
    write_reg(CFG_OWN_MAC, 48'h0);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      r.op = OP_REG; r.ip = 32'h5000_0000 + 32'(i); r.mac = 48'h1000 + 48'(i);
      send_request(r);
    end
    r.op = OP_LOOKUP; r.ip = 32'h6000_0000;
    send_request(r);
    r.op = OP_REG;
    send_request(r);
    send_request(good_rx(16'd1, 48'h9, 32'h6000_0001, 32'h0));
    send_request(good_rx(16'd1, 48'h9, 32'h5000_0003, 32'h0));
    drain();
  endtask

  task automatic test_random();
    arp_req_t r;
    for (int n = 0; n < 1750; n++) begin
      if (n % 350 == 0) begin
        drain();
        write_reg(CFG_OWN_IP, {16'h0, $urandom});
        write_reg(CFG_OWN_MAC, 48'({$urandom, $urandom}));
        for (int k = 0; k < 8; k++)
          ip_pool[k] = (k < 4) ? 32'h5000_0000 + $urandom_range(0, 15) : $urandom;
        ip_pool[7] = my_ip;
      end
      r = rand_req();
      send_request(r);
    end
    drain();
  endtask

  task automatic check_response(arp_resp_t e);
    arp_resp_t a;
    a = '{status, result_mac, send_frame, frame_oper, frame_dest_mac,
          frame_target_mac, frame_target_ip};
    if (a !== e) begin
      errors++;
      $display("%0t mismatch: expected %h actual %h", $time, e, a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none actual %h", $time,
                   {status, result_mac, send_frame});
        end else check_response(expected_q.pop_front());
      end
      out_ready <= ($time / 2000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_res[i] = 1'b0;
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
    end
    @(posedge clk);
    test_random();
    test_directed();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("arp_cache_responder_core verification clean");
    end else begin
      $display("arp_cache_responder_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("arp_cache_responder_core verification failed");
    $finish;
  end

endmodule

[arp_cache_responder_core.f]
src/arpc_pkg.sv
src/arpc_ram.sv
src/arp_cache_responder_core.sv
tb/tb_arp_cache_responder_core.sv
